// ===== rtl/ehi_pkg.sv =====
// ----------------------------------------------------------------------------
// ehi_pkg
// Shared constants and types for the edge/hyperplane intersection unit.
// ----------------------------------------------------------------------------
package ehi_pkg;

    // Default coordinate width (signed Q4.12) and fraction bits of t
    localparam int COORD_BITS_DEF      = 16;
    localparam int T_FRACTION_BITS_DEF = 16;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam int REG_SLICE_LEVEL = 0;

    // Classification of one edge, passed from front to back
    typedef struct packed {
        logic hit;   // edge meets the hyperplane within its extent
        logic full;  // t is exactly one, point is the second endpoint
    } t_flags;

endpackage

// ===== rtl/ehi_front.sv =====
// ----------------------------------------------------------------------------
// ehi_front
// Classifies one edge against the slice level and packs a queue entry.
// ----------------------------------------------------------------------------
module ehi_front #(
    parameter int COORD_BITS = 16
) (
    input  logic [COORD_BITS-1:0]   i_slice_level,
    input  logic [COORD_BITS-1:0]   i_a_x,
    input  logic [COORD_BITS-1:0]   i_a_y,
    input  logic [COORD_BITS-1:0]   i_a_z,
    input  logic [COORD_BITS-1:0]   i_a_w,
    input  logic [COORD_BITS-1:0]   i_b_x,
    input  logic [COORD_BITS-1:0]   i_b_y,
    input  logic [COORD_BITS-1:0]   i_b_z,
    input  logic [COORD_BITS-1:0]   i_b_w,
    output logic [8*COORD_BITS+4:0] o_item
);
    import ehi_pkg::*;

    localparam int C = COORD_BITS;

    logic [C:0]   w_num;
    logic [C:0]   w_den;
    logic [C:0]   w_num_neg;
    logic [C:0]   w_den_neg;
    logic [C-1:0] w_num_mag;
    logic [C-1:0] w_den_mag;
    logic [C:0]   w_d_x;
    logic [C:0]   w_d_y;
    logic [C:0]   w_d_z;
    t_flags       w_flags;

    // Form numerator and denominator with one guard bit
    assign w_num = {i_slice_level[C-1], i_slice_level} - {i_a_w[C-1], i_a_w};
    assign w_den = {i_b_w[C-1], i_b_w} - {i_a_w[C-1], i_a_w};

    // Take magnitudes; they always fit in C bits
    assign w_num_neg = ~w_num + {{C{1'b0}}, 1'b1};
    assign w_den_neg = ~w_den + {{C{1'b0}}, 1'b1};
    assign w_num_mag = w_num[C] ? w_num_neg[C-1:0] : w_num[C-1:0];
    assign w_den_mag = w_den[C] ? w_den_neg[C-1:0] : w_den[C-1:0];

    // Hit when 0 <= t <= 1: nonzero den, matching signs, |num| <= |den|
    always_comb begin
        w_flags.hit  = (w_den != '0) &&
                       ((w_num == '0) || (w_num[C] == w_den[C])) &&
                       (w_num_mag <= w_den_mag);
        w_flags.full = (w_num_mag == w_den_mag);
    end

    // Endpoint differences for the point coordinates
    assign w_d_x = {i_b_x[C-1], i_b_x} - {i_a_x[C-1], i_a_x};
    assign w_d_y = {i_b_y[C-1], i_b_y} - {i_a_y[C-1], i_a_y};
    assign w_d_z = {i_b_z[C-1], i_b_z} - {i_a_z[C-1], i_a_z};

    assign o_item = {w_flags, w_num_mag, w_den_mag, i_a_x, i_a_y, i_a_z,
                     w_d_x, w_d_y, w_d_z};

endmodule

// ===== rtl/ehi_queue.sv =====
// ----------------------------------------------------------------------------
// ehi_queue
// Small register queue that decouples classification from computation.
// ----------------------------------------------------------------------------
module ehi_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    import ehi_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    // Store an entry
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/ehi_back.sv =====
// ----------------------------------------------------------------------------
// ehi_back
// Pipelined restoring divider for t, then scaling and offset per coordinate.
// ----------------------------------------------------------------------------
module ehi_back #(
    parameter int COORD_BITS      = 16,
    parameter int T_FRACTION_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [8*COORD_BITS+4:0]      i_item,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic signed [COORD_BITS-1:0] o_point_x,
    output logic signed [COORD_BITS-1:0] o_point_y,
    output logic signed [COORD_BITS-1:0] o_point_z
);
    import ehi_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int T  = T_FRACTION_BITS;
    localparam int PW = T + C + 2;

    // Divider stage registers, stage 0 holds the freshly popped request
    logic           r_vld  [0:T];
    t_flags         r_flg  [0:T];
    logic [C-1:0]   r_rem  [0:T];
    logic [T-1:0]   r_quo  [0:T];
    logic [C-1:0]   r_ad   [0:T];
    logic [3*C-1:0] r_a    [0:T];
    logic [3*C+2:0] r_d    [0:T];

    // Product stage
    logic                 r_p_vld;
    t_flags               r_p_flg;
    logic [3*C-1:0]       r_p_a;
    logic [3*C+2:0]       r_p_d;
    logic signed [PW-1:0] r_prod [0:2];

    t_flags     w_in_flg;
    logic [C-1:0] w_in_an;
    logic [C-1:0] w_in_ad;
    logic [3*C-1:0] w_in_a;
    logic [3*C+2:0] w_in_d;

    assign {w_in_flg, w_in_an, w_in_ad, w_in_a, w_in_d} = i_item;

    // Load stage 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flg[0] <= w_in_flg;
        r_rem[0] <= w_in_an;
        r_quo[0] <= '0;
        r_ad[0]  <= w_in_ad;
        r_a[0]   <= w_in_a;
        r_d[0]   <= w_in_d;
    end

    // One quotient bit per stage
    for (genvar s = 0; s < T; s++) begin : g_div
        logic [C:0] w_shift;
        logic [C:0] w_diff;
        logic       w_bit;

        assign w_shift = {r_rem[s], 1'b0};
        assign w_diff  = w_shift - {1'b0, r_ad[s]};
        assign w_bit   = (w_shift >= {1'b0, r_ad[s]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s+1] <= w_bit ? w_diff[C-1:0] : w_shift[C-1:0];
            r_quo[s+1] <= {r_quo[s][T-2:0], w_bit};
            r_flg[s+1] <= r_flg[s];
            r_ad[s+1]  <= r_ad[s];
            r_a[s+1]   <= r_a[s];
            r_d[s+1]   <= r_d[s];
        end
    end

    // Scale each difference by t
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= r_vld[T];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_flg <= r_flg[T];
        r_p_a   <= r_a[T];
        r_p_d   <= r_d[T];
        for (int k = 0; k < 3; k++) begin
            r_prod[k] <= PW'($signed({1'b0, r_quo[T]}) *
                             $signed(r_d[T][(C+1)*(2-k) +: C+1]));
        end
    end

    // Floor the product (or take the whole difference when t is one), add the first endpoint, zero on no hit
    logic signed [C-1:0] n_point [0:2];

    always_comb begin
        logic signed [C:0] w_step;
        logic signed [C:0] w_sum;
        for (int k = 0; k < 3; k++) begin
            w_step = r_p_flg.full ? $signed(r_p_d[(C+1)*(2-k) +: C+1])
                                  : $signed(r_prod[k][T +: C+1]);
            w_sum  = $signed({r_p_a[C*(2-k)+C-1], r_p_a[C*(2-k) +: C]}) + w_step;
            n_point[k] = r_p_flg.hit ? w_sum[C-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_hit     <= r_p_flg.hit;
        o_point_x <= n_point[0];
        o_point_y <= n_point[1];
        o_point_z <= n_point[2];
    end

endmodule

// ===== rtl/edge_hyperplane_intersect_unit.sv =====
// ----------------------------------------------------------------------------
// edge_hyperplane_intersect_unit
// Intersects a 4D edge with the hyperplane w = slice level.
// ----------------------------------------------------------------------------
// The unit takes one edge per clock (start high while busy is low) and
// returns exactly one result per edge, in order, after passing the front
// queue, the divider input register, the pipelined divider stages, the
// multiplier registers and the output register. o_valid marks each
// result for a single cycle and the receiver cannot hold it off; busy is
// high only during reset. The slice level is written over the APB port at
// byte address 0 and is sampled as each edge is taken.
module edge_hyperplane_intersect_unit
    #(
    parameter int COORD_BITS      = ehi_pkg::COORD_BITS_DEF,
    parameter int T_FRACTION_BITS = ehi_pkg::T_FRACTION_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [1:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // Request
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_a_x,
    input  logic signed [COORD_BITS-1:0] i_a_y,
    input  logic signed [COORD_BITS-1:0] i_a_z,
    input  logic signed [COORD_BITS-1:0] i_a_w,
    input  logic signed [COORD_BITS-1:0] i_b_x,
    input  logic signed [COORD_BITS-1:0] i_b_y,
    input  logic signed [COORD_BITS-1:0] i_b_z,
    input  logic signed [COORD_BITS-1:0] i_b_w,
    // Result
    output logic                         o_valid,
    output logic                         o_hit,
    output logic signed [COORD_BITS-1:0] o_point_x,
    output logic signed [COORD_BITS-1:0] o_point_y,
    output logic signed [COORD_BITS-1:0] o_point_z
);
    import ehi_pkg::*;

    localparam int ITEM_W  = 8 * COORD_BITS + 5;
    localparam int LATENCY = T_FRACTION_BITS + 4;

    logic [COORD_BITS-1:0] r_slice_level;
    logic [ITEM_W-1:0]     w_push_item;
    logic [ITEM_W-1:0]     w_pop_item;
    logic                  w_q_empty;
    logic                  w_q_full;
    logic                  w_accept;
    logic                  w_cfg_wr;

    // Configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[1:0] == 2'(REG_SLICE_LEVEL * 4));
    assign prdata   = 32'(r_slice_level);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_level <= '0;
        end else if (w_cfg_wr) begin
            r_slice_level <= pwdata[COORD_BITS-1:0];
        end
    end

    // Accept a request whenever the queue has room and reset is released
    assign busy     = w_q_full || !i_rst_n;
    assign w_accept = start && !busy;

    ehi_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_slice_level (r_slice_level),
        .i_a_x         (i_a_x),
        .i_a_y         (i_a_y),
        .i_a_z         (i_a_z),
        .i_a_w         (i_a_w),
        .i_b_x         (i_b_x),
        .i_b_y         (i_b_y),
        .i_b_z         (i_b_z),
        .i_b_w         (i_b_w),
        .o_item        (w_push_item)
    );

    ehi_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_push_item),
        .i_pop   (!w_q_empty),
        .o_data  (w_pop_item),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    ehi_back #(
        .COORD_BITS      (COORD_BITS),
        .T_FRACTION_BITS (T_FRACTION_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (!w_q_empty),
        .i_item    (w_pop_item),
        .o_valid   (o_valid),
        .o_hit     (o_hit),
        .o_point_x (o_point_x),
        .o_point_y (o_point_y),
        .o_point_z (o_point_z)
    );

    // Every request yields a result after the fixed latency
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_valid)
        else $error("request produced no result");

    // No result without a matching request
    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LATENCY))
        else $error("result without request");

    // Back end drains every cycle, so the queue never fills
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_q_full)
        else $error("queue filled up");

    // A miss reports the origin
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_point_x == '0 && o_point_y == '0 &&
                                 o_point_z == '0))
        else $error("miss with nonzero point");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the edge/hyperplane intersection unit: a table of
// hand-picked edges, then random edges biased to cross the slice level, all
// compared against typed results or a bit-accurate predictor under several
// slice levels and request spacings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int COORD_W   = ehi_pkg::COORD_BITS_DEF;
    localparam int TF_BITS   = ehi_pkg::T_FRACTION_BITS_DEF;
    localparam int LATENCY   = TF_BITS + 4;
    localparam int WDOG_MAX  = 2000;
    localparam int N_PHASES  = 5;
    localparam int PHASE_LEN = 170;
    localparam int N_ROWS    = 12;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord a_x, a_y, a_z, a_w;
        t_coord b_x, b_y, b_z, b_w;
    } t_edge;

    typedef struct packed {
        logic   hit;
        t_coord x, y, z;
    } t_point;

    typedef struct packed {
        t_edge  e;
        logic   typed;
        t_point p;
    } t_edge_row;

    // Hand-picked edges at slice level zero; typed results where obvious
    localparam t_edge_row DIRECTED_ROWS [N_ROWS] = '{
        // equal w, all zero
        '{'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
            16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000}, 1'b1,
          '{1'b0, 16'sh0000, 16'sh0000, 16'sh0000}},
        // equal w off the plane
        '{'{16'sh7fff, 16'sh8000, 16'sh1234, 16'sh0005,
            16'sh0001, 16'sh0002, 16'sh0003, 16'sh0005}, 1'b1,
          '{1'b0, 16'sh0000, 16'sh0000, 16'sh0000}},
        // first endpoint on the plane, point is a
        '{'{16'sh7fff, 16'sh8000, 16'sh0123, 16'sh0000,
            16'sh8000, 16'sh7fff, 16'shffff, 16'sh0064}, 1'b1,
          '{1'b1, 16'sh7fff, 16'sh8000, 16'sh0123}},
        // second endpoint on the plane, t is one, point is b
        '{'{16'sh1111, 16'sh2222, 16'sh3333, 16'shff9c,
            16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0000}, 1'b1,
          '{1'b1, 16'sh8000, 16'sh7fff, 16'sh0000}},
        // both above the plane
        '{'{16'sh0100, 16'sh0200, 16'sh0300, 16'sh0064,
            16'sh0400, 16'sh0500, 16'sh0600, 16'sh00c8}, 1'b1,
          '{1'b0, 16'sh0000, 16'sh0000, 16'sh0000}},
        // both below, moving away
        '{'{16'sh0100, 16'sh0200, 16'sh0300, 16'shffce,
            16'sh0400, 16'sh0500, 16'sh0600, 16'shffc4}, 1'b1,
          '{1'b0, 16'sh0000, 16'sh0000, 16'sh0000}},
        // matching signs but t above one
        '{'{16'sh0100, 16'sh0200, 16'sh0300, 16'sh0005,
            16'sh0400, 16'sh0500, 16'sh0600, 16'sh0001}, 1'b1,
          '{1'b0, 16'sh0000, 16'sh0000, 16'sh0000}},
        // widest span of w and coordinates
        '{'{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh8000,
            16'sh7fff, 16'sh8000, 16'shffff, 16'sh7fff}, 1'b0, '0},
        '{'{16'sh7fff, 16'sh8000, 16'sh0001, 16'sh7fff,
            16'sh8000, 16'sh7fff, 16'shfffe, 16'sh8000}, 1'b0, '0},
        // t of one half
        '{'{16'sh0000, 16'sh1000, 16'shf000, 16'shffff,
            16'sh2000, 16'shf000, 16'sh1000, 16'sh0001}, 1'b0, '0},
        // t of one third, descending w
        '{'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0001,
            16'sh7fff, 16'sh8000, 16'sh3000, 16'shfffe}, 1'b0, '0},
        // most negative w to plane, t is one
        '{'{16'shaaaa, 16'sh5555, 16'sh0f0f, 16'sh8000,
            16'sh5555, 16'shaaaa, 16'shf0f0, 16'sh0000}, 1'b1,
          '{1'b1, 16'sh5555, 16'shaaaa, 16'shf0f0}}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        start, busy;
    t_edge       edge_in;
    logic        o_valid, o_hit;
    t_coord      o_point_x, o_point_y, o_point_z;

    t_point      crossing_q[$];
    t_coord      slice_copy;
    int          fails, edges_sent, hits_sent, results_seen, wdog_cnt;

    edge_hyperplane_intersect_unit DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .start     (start),
        .busy      (busy),
        .i_a_x     (edge_in.a_x),
        .i_a_y     (edge_in.a_y),
        .i_a_z     (edge_in.a_z),
        .i_a_w     (edge_in.a_w),
        .i_b_x     (edge_in.b_x),
        .i_b_y     (edge_in.b_y),
        .i_b_z     (edge_in.b_z),
        .i_b_w     (edge_in.b_w),
        .o_valid   (o_valid),
        .o_hit     (o_hit),
        .o_point_x (o_point_x),
        .o_point_y (o_point_y),
        .o_point_z (o_point_z)
    );

    // Generate the clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Compute the crossing of one edge with w = lvl
    function automatic t_point predict_crossing(t_edge e, t_coord lvl);
        longint num, den, an, ad, rem, tf, p;
        longint av [3];
        longint bv [3];
        t_coord pts [3];
        logic   full;
        t_point r;
        r   = '0;
        num = longint'(lvl) - longint'(e.a_w);
        den = longint'(e.b_w) - longint'(e.a_w);
        an  = (num < 0) ? -num : num;
        ad  = (den < 0) ? -den : den;
        if (den == 0 || (num != 0 && ((num < 0) != (den < 0))) || an > ad)
            return r;
        r.hit = 1'b1;
        full  = (an == ad);
        tf    = 0;
        rem   = an;
        // Restoring division for the fraction bits of t
        if (!full) begin
            for (int i = 0; i < TF_BITS; i++) begin
                rem = rem << 1;
                tf  = tf << 1;
                if (rem >= ad) begin
                    rem = rem - ad;
                    tf  = tf | 1;
                end
            end
        end
        av[0] = e.a_x; av[1] = e.a_y; av[2] = e.a_z;
        bv[0] = e.b_x; bv[1] = e.b_y; bv[2] = e.b_z;
        for (int i = 0; i < 3; i++) begin
            p = full ? bv[i] : av[i] + ((tf * (bv[i] - av[i])) >>> TF_BITS);
            pts[i] = p[COORD_W-1:0];
        end
        r.x = pts[0];
        r.y = pts[1];
        r.z = pts[2];
        return r;
    endfunction

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic t_coord rand_coord();
        unique case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            default: return t_coord'($urandom);
        endcase
    endfunction

    // Build an edge, mostly one that straddles the slice level
    function automatic t_edge make_edge(t_coord lvl);
        t_edge e;
        int    s, mode, lim;
        e = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        s    = lvl;
        mode = $urandom_range(99);
        if (mode < 55) begin
            if (e.a_w <= lvl) begin
                lim = ($urandom_range(3) == 0 && s + 16 < 32767) ? s + 16 : 32767;
                e.b_w = t_coord'(rand_between(s, lim));
            end else begin
                lim = ($urandom_range(3) == 0 && s - 16 > -32768) ? s - 16 : -32768;
                e.b_w = t_coord'(rand_between(lim, s));
            end
        end else if (mode < 65) begin
            e.b_w = e.a_w;
        end else if (mode < 75) begin
            if ($urandom_range(1))
                e.a_w = lvl;
            else
                e.b_w = lvl;
        end
        return e;
    endfunction

    // Present one request and hold it until taken; call at a falling edge
    task automatic send_edge(t_edge e, logic use_typed, t_point typed_pt);
        t_point exp_pt;
        edge_in = e;
        start   = 1'b1;
        // busy only moves at rising edges, so look at it mid-cycle
        while (busy)
            @(negedge i_clk);
        @(posedge i_clk);
        exp_pt = use_typed ? typed_pt : predict_crossing(e, slice_copy);
        crossing_q = {crossing_q, exp_pt};
        edges_sent++;
        if (exp_pt.hit)
            hits_sent++;
        @(negedge i_clk);
    endtask

    // Drop start for a random number of cycles, with junk on the fields
    task automatic idle_gap(int pct);
        while ($urandom_range(99) < pct) begin
            start   = 1'b0;
            edge_in = {$urandom, $urandom, $urandom, $urandom};
            @(negedge i_clk);
        end
    endtask

    task automatic drain();
        start = 1'b0;
        while (crossing_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Write the slice level and read it back; call at a falling edge while idle
    task automatic write_slice(t_coord lvl);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 2'(4 * ehi_pkg::REG_SLICE_LEVEL);
        pwdata  = 32'(signed'(lvl));
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel       = 1'b0;
        penable    = 1'b0;
        slice_copy = lvl;
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata[COORD_W-1:0] !== lvl) begin
            $error("slice_level readback mismatch: expected %0d, got %0d",
                   lvl, $signed(prdata[COORD_W-1:0]));
            fails++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_point exp_pt;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (crossing_q.size() == 0) begin
                $error("unexpected result: hit %0b point (%0d, %0d, %0d)",
                       o_hit, o_point_x, o_point_y, o_point_z);
                fails++;
            end else begin
                exp_pt = crossing_q.pop_front();
                if (o_hit !== exp_pt.hit) begin
                    $error("hit mismatch: expected %0b, got %0b", exp_pt.hit, o_hit);
                    fails++;
                end
                if (o_point_x !== exp_pt.x) begin
                    $error("point_x mismatch: expected %0d, got %0d", exp_pt.x, o_point_x);
                    fails++;
                end
                if (o_point_y !== exp_pt.y) begin
                    $error("point_y mismatch: expected %0d, got %0d", exp_pt.y, o_point_y);
                    fails++;
                end
                if (o_point_z !== exp_pt.z) begin
                    $error("point_z mismatch: expected %0d, got %0d", exp_pt.z, o_point_z);
                    fails++;
                end
            end
        end
    end

    // Abort when neither requests nor results move for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            wdog_cnt <= 0;
        else
            wdog_cnt <= wdog_cnt + 1;
        if (wdog_cnt >= WDOG_MAX) begin
            $display("timeout: no traffic for %0d cycles", WDOG_MAX);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Sequence the run
    initial begin
        t_coord phase_lvl [N_PHASES];
        int     phase_idle [N_PHASES];
        fails        = 0;
        edges_sent   = 0;
        hits_sent    = 0;
        results_seen = 0;
        wdog_cnt     = 0;
        slice_copy   = '0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        start        = 1'b0;
        edge_in      = '0;

        phase_lvl  = '{16'sh7fff, 16'sh8000, t_coord'($urandom), 16'sh0000, 16'shf000};
        phase_idle = '{0, 75, 29, 0, 75};

        // Hold reset, then release it at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed table at slice level zero
        write_slice(16'sh0000);
        for (int r = 0; r < N_ROWS; r++)
            send_edge(DIRECTED_ROWS[r].e, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].p);
        drain();

        // Random phases, each under its own slice level and spacing
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_slice(phase_lvl[ph]);
            for (int n = 0; n < PHASE_LEN; n++) begin
                // hold off once until every result is back
                if (ph == 1 && n == PHASE_LEN / 2)
                    drain();
                send_edge(make_edge(slice_copy), 1'b0, '0);
                idle_gap(phase_idle[ph]);
            end
            drain();
        end

        // Let any stray result show up
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("Run covered %0d edges (%0d crossings) over %0d slice level writes;",
                 edges_sent, hits_sent, N_PHASES + 1);
        $display("%0d results compared, %0d mismatches.", results_seen, fails);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
